FILE: hdl/tlvd_pkg.sv
// package for the tlv record deframer: codes, phases and result types
`default_nettype none
package tlvd_pkg;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned PaddrWidth  = 3;

  // register index of skip_bytes
  localparam logic [PaddrWidth-3:0] REG_SKIP_BYTES = '0;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } tlvd_phase_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OFFSET_RANGE  = 2'd1,
    ST_TRUNC_HEADER  = 2'd2,
    ST_TRUNC_PAYLOAD = 2'd3
  } tlvd_status_e;

  typedef enum logic {
    EV_RECORD = 1'b0,
    EV_STATUS = 1'b1
  } tlvd_event_e;

  typedef struct packed {
    tlvd_event_e  kind;
    logic [31:0]  rec_type;
    logic [31:0]  rec_length;
    logic [31:0]  rec_offset;
    tlvd_status_e status;
    logic         last;
  } tlvd_result_t;

  typedef struct packed {
    logic [1:0]   num;
    tlvd_result_t first;
    tlvd_result_t second;
  } tlvd_push_t;

endpackage
`default_nettype wire

FILE: hdl/tlvd_parser.sv
// per-word parse state and result generation
`default_nettype none
module tlvd_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              byte_present_i,
  input  wire logic              end_of_data_i,
  input  wire logic [31:0]       skip_bytes_i,
  output tlvd_pkg::tlvd_push_t   push_o
);
  import tlvd_pkg::*;

  tlvd_phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] start_q, start_d;

  tlvd_phase_e  ph_eff;
  tlvd_phase_e  ph_after;
  logic         rec_hit;
  tlvd_result_t rec_res;
  tlvd_result_t st_res;
  tlvd_status_e st_code;
  logic [31:0]  remain_dec;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    hcnt_d   = hcnt_q;
    shift_d  = shift_q;
    remain_d = remain_q;
    start_d  = start_q;
    rec_hit  = 1'b0;
    remain_dec = remain_q - 32'd1;

    ph_eff = phase_q;
    if (phase_q == PH_SKIP && pos_q >= skip_bytes_i) begin
      ph_eff = PH_HEADER;
    end

    if (byte_present_i) begin
      phase_d = ph_eff;
      case (ph_eff)
        PH_HEADER: begin
          if (hcnt_q == 3'd0) begin
            start_d = pos_q;
            shift_d = '0;
          end
          shift_d[{hcnt_q, 3'b000} +: 8] = data_byte_i;
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_q == 3'(HeaderBytes - 1)) begin
            if (shift_d[63:32] == 32'd0) begin
              rec_hit = 1'b1;
            end else begin
              remain_d = shift_d[63:32];
              phase_d  = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          remain_d = remain_dec;
          if (remain_dec == 32'd0) begin
            rec_hit = 1'b1;
            phase_d = PH_HEADER;
          end
        end
        default: ;
      endcase
      if (pos_q != 32'hFFFF_FFFF) begin
        pos_d = pos_q + 32'd1;
      end
    end

    // status sees the state after the byte of the same word
    ph_after = phase_d;
    case (ph_after)
      PH_SKIP:    st_code = (pos_d < skip_bytes_i) ? ST_OFFSET_RANGE : ST_OK;
      PH_PAYLOAD: st_code = ST_TRUNC_PAYLOAD;
      default:    st_code = (hcnt_d != 3'd0) ? ST_TRUNC_HEADER : ST_OK;
    endcase

    rec_res.kind       = EV_RECORD;
    rec_res.rec_type   = shift_d[31:0];
    rec_res.rec_length = shift_d[63:32];
    rec_res.rec_offset = start_d;
    rec_res.status     = ST_OK;
    rec_res.last       = ~end_of_data_i;

    st_res.kind       = EV_STATUS;
    st_res.rec_type   = '0;
    st_res.rec_length = '0;
    st_res.rec_offset = '0;
    st_res.status     = st_code;
    st_res.last       = 1'b1;

    push_o.num    = 2'd0;
    push_o.first  = rec_res;
    push_o.second = st_res;
    if (take_i) begin
      if (rec_hit && end_of_data_i) begin
        push_o.num = 2'd2;
      end else if (rec_hit) begin
        push_o.num = 2'd1;
      end else if (end_of_data_i) begin
        push_o.num   = 2'd1;
        push_o.first = st_res;
      end
    end

    // end of stream: back to a fresh stream
    if (end_of_data_i) begin
      phase_d  = PH_SKIP;
      pos_d    = '0;
      hcnt_d   = '0;
      shift_d  = '0;
      remain_d = '0;
      start_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SKIP;
      pos_q    <= '0;
      hcnt_q   <= '0;
      shift_q  <= '0;
      remain_q <= '0;
      start_q  <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      hcnt_q   <= hcnt_d;
      shift_q  <= shift_d;
      remain_q <= remain_d;
      start_q  <= start_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tlvd_out_queue.sv
// small result queue: up to two pushes and one pop per cycle
`default_nettype none
module tlvd_out_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tlvd_pkg::tlvd_push_t push_i,
  input  wire logic                pop_i,
  output wire logic                room_o,
  output wire logic                valid_o,
  output tlvd_pkg::tlvd_result_t   head_o
);
  import tlvd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tlvd_result_t        mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PtrW-1:0]     wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);
  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  // two free slots needed for a word that may yield two results
  assign room_o    = (cnt_q <= CntW'(QueueDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    cnt_d    = cnt_q + CntW'(push_i.num) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tlv_record_deframer.sv
// top level of the tlv record deframer
// usage:
//   input channel: one stream byte per word (data_byte_i with byte_present_i),
//   end_of_data_i closes the stream; a word with neither is dropped silently
//   output channel: one word per record (type, length, header offset) once its
//   payload is complete, and one status word at each end of stream
//   skip_bytes is written over the apb port while the block is idle
// throughput: one input word per cycle while in_stall_o is low; a word ending
//   a record and the stream at once yields two output words, which drain one
//   per cycle while out_stall_i is low; each result is captured in a result
//   queue entry at the accept edge and offered from the queue head
// stall: results wait in a four-entry queue; in_stall_o rises when fewer than
//   two entries are free, so input keeps flowing while the receiver stalls
//   briefly
// reset: parse state returns to skipping with position zero, the queue empties
//   and skip_bytes clears to zero; no clearing pass
`default_nettype none
module tlv_record_deframer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           in_valid_i,
  output wire logic                           in_stall_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           byte_present_i,
  input  wire logic                           end_of_data_i,
  // result stream
  output wire logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output wire logic                           event_kind_o,
  output wire logic [31:0]                    record_type_o,
  output wire logic [31:0]                    record_length_o,
  output wire logic [31:0]                    record_offset_o,
  output wire logic [1:0]                     status_code_o,
  output wire logic                           last_of_run_o,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tlvd_pkg::PaddrWidth-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output wire logic [31:0]                    prdata,
  output wire logic                           pready
);
  import tlvd_pkg::*;

  logic [31:0]  skip_bytes_q;
  logic         cfg_wr;
  logic [PaddrWidth-3:0] reg_idx;
  logic         take;
  logic         room;
  tlvd_push_t   push;
  tlvd_result_t head;

  // apb register file: one register, always ready
  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrWidth-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (reg_idx == REG_SKIP_BYTES) ? skip_bytes_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_bytes_q <= '0;
    end else if (cfg_wr && reg_idx == REG_SKIP_BYTES) begin
      skip_bytes_q <= pwdata;
    end
  end

  // input handshake
  assign in_stall_o = ~room;
  assign take       = in_valid_i & room;

  tlvd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_data_i  (end_of_data_i),
    .skip_bytes_i   (skip_bytes_q),
    .push_o         (push)
  );

  tlvd_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o & ~out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  // result fields
  assign event_kind_o    = head.kind;
  assign record_type_o   = head.rec_type;
  assign record_length_o = head.rec_length;
  assign record_offset_o = head.rec_offset;
  assign status_code_o   = head.status;
  assign last_of_run_o   = head.last;

endmodule
`default_nettype wire
